>>> rtl/pcrc_pkg.sv
// Shared types, constants and the CRC-8 byte step for the pressure frame checker.
package pcrc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_TOP  = 8'h80;
    localparam logic [7:0] FAIL_MAX = 8'hFF;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_CRC = 2'd1;
    localparam logic [1:0] STATUS_BUS = 2'd2;

    localparam logic CFG_FRAME_MODE = 1'b0;
    localparam logic CFG_MAX_FAILS  = 1'b1;

    localparam logic MODE_PRESS_TEMP = 1'b0;
    localparam logic MODE_PRESS_ONLY = 1'b1;

    typedef struct packed {
        logic [15:0] pressure_raw;
        logic [15:0] temperature_raw;
        logic [1:0]  frame_status;
        logic        reset_request;
    } t_result;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/pcrc_frame_engine.sv
// Frame parser: byte position sequencer, running CRC, word holds and failure watchdog.
module pcrc_frame_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_first_byte,
    input  logic               i_bus_error,
    input  logic               i_frame_mode,
    input  logic [7:0]         i_max_fails,
    output logic               o_res_valid,
    output pcrc_pkg::t_result  o_res
);

    localparam logic [2:0] POS_P_HI  = 3'd0;
    localparam logic [2:0] POS_P_LO  = 3'd1;
    localparam logic [2:0] POS_P_CRC = 3'd2;
    localparam logic [2:0] POS_T_HI  = 3'd3;
    localparam logic [2:0] POS_T_LO  = 3'd4;
    localparam logic [2:0] POS_T_CRC = 3'd5;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_hi, n_hi;
    logic [7:0]  r_lo, n_lo;
    logic [15:0] r_press, n_press;
    logic        r_crc_fail, n_crc_fail;
    logic [7:0]  r_fail_cnt, n_fail_cnt;

    logic        restart;
    logic [2:0]  pos;
    logic        crc_fail;
    logic        fail_now;
    logic [7:0]  crc_step;

    always_comb begin
        restart  = i_first_byte && (r_pos != POS_P_HI);
        pos      = restart ? POS_P_HI : r_pos;
        crc_fail = restart ? 1'b0 : r_crc_fail;
        crc_step = pcrc_pkg::crc8_byte(r_crc, i_rx_byte);
        fail_now = crc_fail || (i_rx_byte != r_crc);

        n_pos      = r_pos;
        n_crc      = r_crc;
        n_hi       = r_hi;
        n_lo       = r_lo;
        n_press    = r_press;
        n_crc_fail = r_crc_fail;
        n_fail_cnt = r_fail_cnt;

        o_res_valid            = 1'b0;
        o_res.pressure_raw     = r_press;
        o_res.temperature_raw  = 16'h0000;
        o_res.frame_status     = fail_now ? pcrc_pkg::STATUS_CRC : pcrc_pkg::STATUS_OK;
        o_res.reset_request    = (i_max_fails == 8'h00);

        if (i_accept) begin
            if (i_bus_error) begin
                n_pos      = POS_P_HI;
                n_crc      = pcrc_pkg::CRC_INIT;
                n_crc_fail = 1'b0;
                if (r_fail_cnt != pcrc_pkg::FAIL_MAX) begin
                    n_fail_cnt = r_fail_cnt + 8'd1;
                end
                o_res_valid           = 1'b1;
                o_res.pressure_raw    = 16'h0000;
                o_res.frame_status    = pcrc_pkg::STATUS_BUS;
                o_res.reset_request   = (n_fail_cnt >= i_max_fails);
            end else begin
                n_crc_fail = crc_fail;
                case (pos)
                    POS_P_HI, POS_T_HI: begin
                        n_crc = pcrc_pkg::crc8_byte(pcrc_pkg::CRC_INIT, i_rx_byte);
                        n_hi  = i_rx_byte;
                        n_pos = pos + 3'd1;
                    end
                    POS_P_LO: begin
                        n_crc   = crc_step;
                        n_press = {r_hi, i_rx_byte};
                        n_pos   = POS_P_CRC;
                    end
                    POS_T_LO: begin
                        n_crc = crc_step;
                        n_lo  = i_rx_byte;
                        n_pos = POS_T_CRC;
                    end
                    POS_P_CRC: begin
                        if (i_frame_mode == pcrc_pkg::MODE_PRESS_TEMP) begin
                            n_crc_fail = fail_now;
                            n_pos      = POS_T_HI;
                        end else begin
                            o_res_valid = 1'b1;
                            n_fail_cnt  = 8'h00;
                            n_pos       = POS_P_HI;
                            n_crc       = pcrc_pkg::CRC_INIT;
                            n_crc_fail  = 1'b0;
                        end
                    end
                    default: begin
                        o_res_valid = 1'b1;
                        if (i_frame_mode == pcrc_pkg::MODE_PRESS_TEMP) begin
                            o_res.temperature_raw = {r_hi, r_lo};
                        end
                        n_fail_cnt = 8'h00;
                        n_pos      = POS_P_HI;
                        n_crc      = pcrc_pkg::CRC_INIT;
                        n_crc_fail = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_P_HI;
            r_crc      <= pcrc_pkg::CRC_INIT;
            r_hi       <= 8'h00;
            r_lo       <= 8'h00;
            r_press    <= 16'h0000;
            r_crc_fail <= 1'b0;
            r_fail_cnt <= 8'h00;
        end else begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_hi       <= n_hi;
            r_lo       <= n_lo;
            r_press    <= n_press;
            r_crc_fail <= n_crc_fail;
            r_fail_cnt <= n_fail_cnt;
        end
    end

endmodule

>>> rtl/pressure_frame_crc_checker_core.sv
// Top level of the pressure frame CRC checker: config registers, frame engine, output register.
//
// Usage:
//   Slave stream s_axis_* carries one received byte per item with two flags:
//   first byte of a read and bus error. Master stream m_axis_* carries one
//   result per completed frame (after the third or sixth byte) or per bus
//   error item: pressure and temperature words, frame status, reset request.
//   Bytes that do not finish a frame give no result.
//   Latency: a result is valid on m_axis the cycle after its last byte is taken.
//   Throughput: one byte per cycle while s_axis_tready is high; the CRC byte step
//   and the sequencer update are combinational logic ahead of the state registers.
//   Stall: s_axis_tready is high while the output register is empty or being
//   drained; a result held by a stalled receiver stops every input item until
//   it is taken, and results stay on m_axis unchanged until taken.
//   Reset: synchronous, active low; clears the sequencer, watchdog count and
//   output valid, sets the CRC to 0xFF, and sets frame_mode to 0 and max_fails to 2.
//   Config: write i_cfg_wdata to register i_cfg_addr (0 frame_mode, 1 max_fails)
//   while the block is idle.
module pressure_frame_crc_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [0] first_byte, [1] bus_error
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] pressure_raw, [31:16] temperature_raw
    output logic [2:0]  m_axis_tuser    // [1:0] frame_status, [2] reset_request
);

    logic              r_frame_mode;
    logic [7:0]        r_max_fails;
    logic              r_out_valid;
    pcrc_pkg::t_result r_out;

    logic              accept;
    logic              res_valid;
    pcrc_pkg::t_result res;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_mode <= pcrc_pkg::MODE_PRESS_TEMP;
            r_max_fails  <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pcrc_pkg::CFG_FRAME_MODE: r_frame_mode <= i_cfg_wdata[0];
                pcrc_pkg::CFG_MAX_FAILS:  r_max_fails  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    pcrc_frame_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_rx_byte    (s_axis_tdata),
        .i_first_byte (s_axis_tuser[0]),
        .i_bus_error  (s_axis_tuser[1]),
        .i_frame_mode (r_frame_mode),
        .i_max_fails  (r_max_fails),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Load on a new result, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.temperature_raw, r_out.pressure_raw};
    assign m_axis_tuser  = {r_out.reset_request, r_out.frame_status};

endmodule

>>> rtl/pcrc_checker.sv
// Port-level assertions for the pressure frame CRC checker, bound to the top level.
module pcrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output register state");

    a_bus_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[1] |=>
            m_axis_tvalid && (m_axis_tuser[1:0] == pcrc_pkg::STATUS_BUS))
        else $error("bus error item gave no bus error result");

    a_bus_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == pcrc_pkg::STATUS_BUS) |->
            (m_axis_tdata == 32'h0000_0000))
        else $error("bus error result carries nonzero words");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser[1:0] == pcrc_pkg::STATUS_OK) ||
            (m_axis_tuser[1:0] == pcrc_pkg::STATUS_CRC) ||
            (m_axis_tuser[1:0] == pcrc_pkg::STATUS_BUS))
        else $error("illegal frame status");

endmodule

bind pressure_frame_crc_checker_core pcrc_checker u_pcrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
